// ===== sv/depth_image_unprojection_unit_macros.svh =====
// Assertion macros for the depth image unprojection unit.
`ifndef DEPTH_IMAGE_UNPROJECTION_UNIT_MACROS_SVH
`define DEPTH_IMAGE_UNPROJECTION_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define DIU_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define DIU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define DIU_ASSERT_IMP(label, clk, rst, ante, cons)
`define DIU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== sv/diu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diu_pkg
// Types, constants and codes shared by the depth image unprojection unit.
// ----------------------------------------------------------------------------
package diu_pkg;

   localparam int ImageWidthDefault  = 640;
   localparam int ImageHeightDefault = 480;
   localparam int SkipDefault        = 2;
   localparam int CsrIndexWidth      = 3;
   localparam int CsrDataWidth       = 24;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_DEPTH_UNIT    = 3'd0,
      CSR_MIN_DEPTH     = 3'd1,
      CSR_MAX_DEPTH     = 3'd2,
      CSR_INV_FOCAL_X   = 3'd3,
      CSR_INV_FOCAL_Y   = 3'd4,
      CSR_CENTER_X      = 3'd5,
      CSR_CENTER_Y      = 3'd6,
      CSR_BORDER_MARGIN = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic               cmd;
      logic [15:0]        depth_raw;
      logic               first_of_frame;
      logic [3:0]         pose_index;
      logic signed [31:0] pose_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic [18:0]        point_index;
   } rsp_payload_type;

   typedef struct packed {
      logic [23:0] depth_unit;
      logic [23:0] min_depth;
      logic [23:0] max_depth;
      logic [23:0] inv_focal_x;
      logic [23:0] inv_focal_y;
      logic [15:0] center_x;
      logic [15:0] center_y;
      logic [6:0]  border_margin;
   } csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DEPTH,
      ST_CLAMP,
      ST_FOCAL,
      ST_PROJ_HI,
      ST_PROJ_LO,
      ST_PROJ_SUM,
      ST_ROT,
      ST_ACC,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_SEL_X,
      OP_SEL_Y
   } axis_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic     load;
      logic     do_depth;
      logic     do_clamp;
      logic     do_focal;
      logic     do_hi;
      logic     do_lo;
      logic     do_sum;
      logic     do_rot;
      logic     do_acc;
      logic     clear_acc;
      logic [1:0] axis;
      logic [1:0] tap;
      logic     emit;
   } dp_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic is_pose;
      logic selected;
      logic keep;
   } dp_status_type;

endpackage

// ===== sv/diu_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// diu_datapath
// Pose store, pixel counters and the shared multiplier datapath.
// ----------------------------------------------------------------------------
module diu_datapath #(
   parameter int ImageWidth  = diu_pkg::ImageWidthDefault,
   parameter int ImageHeight = diu_pkg::ImageHeightDefault,
   parameter int Skip        = diu_pkg::SkipDefault
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire diu_pkg::req_payload_type req_payload,
   input  wire diu_pkg::csr_type         csr,
   input  wire diu_pkg::dp_cmd_type      cmd,
   output diu_pkg::dp_status_type        status,
   output diu_pkg::rsp_payload_type      result
);
   import diu_pkg::*;

   localparam int ColW  = $clog2(ImageWidth);
   localparam int RowW  = $clog2(ImageHeight);
   localparam int SkipW = (Skip > 1) ? $clog2(Skip) : 1;

   // Margin modulo the skip, for every margin the register can hold.
   function automatic logic [127:0][SkipW-1:0] margin_phases();
      logic [127:0][SkipW-1:0] t;
      for (int i = 0; i < 128; i++) t[i] = SkipW'(i % Skip);
      return t;
   endfunction

   localparam logic [127:0][SkipW-1:0] MarginPhase = margin_phases();

   req_payload_type req_ff;
   logic signed [31:0] pose_ff [12];
   logic [ColW-1:0] col_ff;
   logic [RowW-1:0] row_ff;
   logic [18:0] count_ff;
   logic [ColW-1:0] u_ff;
   logic [RowW-1:0] v_ff;
   logic [SkipW-1:0] cph_ff, rph_ff;
   logic [39:0] dprod_ff;
   logic [23:0] depth_ff;
   logic keep_ff, sel_ff;
   logic [47:0] fprod_ff;
   logic signed [16:0] du_ff;
   logic [16:0] mag_ff;
   logic [47:0] a_ff;
   logic [41:0] b_ff;
   logic signed [32:0] cam_ff [2];
   logic signed [63:0] rprod_ff;
   logic signed [49:0] acc_ff;
   logic signed [31:0] out_ff [3];

   function automatic logic [ColW-1:0] col_eff();
      return req_ff.first_of_frame ? '0 : col_ff;
   endfunction
   function automatic logic [RowW-1:0] row_eff();
      return req_ff.first_of_frame ? '0 : row_ff;
   endfunction

   // Selection of a position inside the margin on the skip grid. The phase
   // registers hold each counter modulo the skip, so a position lies on the
   // grid when its phase equals that of the margin.
   logic col_in_rng, row_in_rng;
   logic [SkipW-1:0] cph_eff, rph_eff, mph;
   always_comb begin
      col_in_rng = (12'(col_eff()) >= 12'(csr.border_margin))
         && (12'(col_eff()) + 12'(csr.border_margin) < 12'(ImageWidth));
      row_in_rng = (12'(row_eff()) >= 12'(csr.border_margin))
         && (12'(row_eff()) + 12'(csr.border_margin) < 12'(ImageHeight));
      cph_eff = req_ff.first_of_frame ? '0 : cph_ff;
      rph_eff = req_ff.first_of_frame ? '0 : rph_ff;
      mph     = MarginPhase[csr.border_margin];
   end

   assign status.is_pose  = req_ff.cmd;
   assign status.selected = sel_ff;
   assign status.keep     = keep_ff;

   logic signed [16:0] du_c;
   logic [23:0] inv_c;
   logic signed [31:0] r_mux;
   logic signed [32:0] cam_mux;
   logic signed [49:0] acc_sum;
   logic [36:0] rsum;
   logic [32:0] d_round;
   always_comb begin
      if (cmd.axis == 2'(OP_SEL_X)) begin
         du_c  = $signed(17'({u_ff, 5'b0})) - $signed({1'b0, csr.center_x});
         inv_c = csr.inv_focal_x;
      end else begin
         du_c  = $signed(17'({v_ff, 5'b0})) - $signed({1'b0, csr.center_y});
         inv_c = csr.inv_focal_y;
      end
      r_mux = pose_ff[4'(cmd.axis) * 4'd3 + 4'(cmd.tap)];
      case (cmd.tap)
         2'd0:    cam_mux = cam_ff[0];
         2'd1:    cam_mux = cam_ff[1];
         default: cam_mux = $signed({9'b0, depth_ff});
      endcase
      acc_sum = acc_ff + 50'(rprod_ff >>> 16);
      rsum = 37'(a_ff[47:5]) + 37'(({19'b0, a_ff[4:0], 24'b0} + {6'b0, b_ff}) >> 29);
      d_round = 33'(dprod_ff[39:8]) + 33'(dprod_ff[7]);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_payload;
      if (reset) begin
         col_ff <= '0; row_ff <= '0; count_ff <= '0;
         cph_ff <= '0; rph_ff <= '0;
         for (int i = 0; i < 12; i++) pose_ff[i] <= '0;
      end else begin
         if (cmd.do_depth) begin
            if (req_ff.cmd) begin
               if (req_ff.pose_index < 4'd12) pose_ff[req_ff.pose_index] <= req_ff.pose_value;
            end else begin
               u_ff <= col_eff();
               v_ff <= row_eff();
               sel_ff <= col_in_rng && row_in_rng && (cph_eff == mph) && (rph_eff == mph);
               if (req_ff.first_of_frame) count_ff <= '0;
               if (col_eff() == ColW'(ImageWidth - 1)) begin
                  col_ff <= '0;
                  cph_ff <= '0;
                  if (row_eff() == RowW'(ImageHeight - 1)) begin
                     row_ff <= '0;
                     rph_ff <= '0;
                  end else begin
                     row_ff <= row_eff() + 1'b1;
                     rph_ff <= (rph_eff == SkipW'(Skip - 1)) ? '0 : rph_eff + 1'b1;
                  end
               end else begin
                  col_ff <= col_eff() + 1'b1;
                  cph_ff <= (cph_eff == SkipW'(Skip - 1)) ? '0 : cph_eff + 1'b1;
                  row_ff <= row_eff();
                  rph_ff <= rph_eff;
               end
            end
            dprod_ff <= req_ff.depth_raw * csr.depth_unit;
         end
         if (cmd.emit) count_ff <= count_ff + 1'b1;
      end
      if (cmd.do_clamp) begin
         if (req_ff.depth_raw == 16'd0 || d_round > 33'(csr.max_depth)) begin
            depth_ff <= csr.max_depth;
            keep_ff  <= 1'b1;
         end else begin
            depth_ff <= d_round[23:0];
            keep_ff  <= (d_round[23:0] >= csr.min_depth);
         end
      end
      if (cmd.do_focal) begin
         fprod_ff <= depth_ff * inv_c;
         du_ff    <= du_c;
         mag_ff   <= du_c[16] ? 17'(-du_c) : 17'(du_c);
      end
      if (cmd.do_hi) a_ff <= 48'(mag_ff * fprod_ff[47:24]);
      if (cmd.do_lo) b_ff <= 42'(mag_ff * fprod_ff[23:0]) + 42'h1000_0000;
      if (cmd.do_sum) begin
         if (rsum > 37'h80000000) begin
            cam_ff[1'(cmd.axis - 2'd1)] <= du_ff[16] ? -33'sh80000000 : 33'sh7fffffff;
         end else if (du_ff[16]) begin
            cam_ff[1'(cmd.axis - 2'd1)] <= -$signed({1'b0, rsum[31:0]});
         end else begin
            cam_ff[1'(cmd.axis - 2'd1)] <= (rsum[31]) ? 33'sh7fffffff
                                                      : $signed({1'b0, rsum[31:0]});
         end
      end
      if (cmd.do_rot) rprod_ff <= r_mux * cam_mux + 64'sd32768;
      if (cmd.clear_acc) acc_ff <= 50'(pose_ff[4'd9 + 4'(cmd.axis)]);
      if (cmd.do_acc) begin
         acc_ff <= acc_sum;
         if (cmd.tap == 2'd2) begin
            if (acc_sum > 50'sh7fffffff)
               out_ff[cmd.axis] <= 32'sh7fffffff;
            else if (acc_sum < -50'sh80000000)
               out_ff[cmd.axis] <= -32'sh80000000;
            else
               out_ff[cmd.axis] <= acc_sum[31:0];
         end
      end
      if (cmd.emit) begin
         result.point_x     <= out_ff[0];
         result.point_y     <= out_ff[1];
         result.point_z     <= out_ff[2];
         result.point_index <= count_ff;
      end
   end
endmodule
`default_nettype wire

// ===== sv/diu_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// diu_controller
// Sequences one request through the shared datapath and the result handshake.
// ----------------------------------------------------------------------------
`include "depth_image_unprojection_unit_macros.svh"
module diu_controller (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire diu_pkg::dp_status_type status,
   output diu_pkg::dp_cmd_type         cmd
);
   import diu_pkg::*;

   state_type state_ff, state_in;
   logic [1:0] axis_ff, axis_in, tap_ff, tap_in;
   logic valid_ff, valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; axis_ff <= '0; tap_ff <= '0; valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; axis_ff <= axis_in; tap_ff <= tap_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;

   always_comb begin
      state_in = state_ff; axis_in = axis_ff; tap_in = tap_ff;
      valid_in = valid_ff && !rsp_ready;
      cmd = '0;
      cmd.axis = axis_ff;
      cmd.tap  = tap_ff;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
            if (req_valid) state_in = ST_DEPTH;
         end
         ST_DEPTH: begin
            cmd.do_depth = 1'b1;
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            if (status.is_pose || !status.selected) state_in = ST_IDLE;
            else begin
               cmd.do_clamp = 1'b1;
               axis_in = 2'(OP_SEL_X);
               state_in = ST_FOCAL;
            end
         end
         ST_FOCAL: begin
            if (!status.keep) state_in = ST_IDLE;
            else begin
               cmd.do_focal = 1'b1;
               state_in = ST_PROJ_HI;
            end
         end
         ST_PROJ_HI: begin cmd.do_hi = 1'b1; state_in = ST_PROJ_LO; end
         ST_PROJ_LO: begin cmd.do_lo = 1'b1; state_in = ST_PROJ_SUM; end
         ST_PROJ_SUM: begin
            cmd.do_sum = 1'b1;
            if (axis_ff == 2'(OP_SEL_X)) begin
               axis_in = 2'(OP_SEL_Y);
               state_in = ST_FOCAL;
            end else begin
               axis_in = 2'd0; tap_in = 2'd0;
               state_in = ST_ROT;
            end
         end
         ST_ROT: begin
            cmd.do_rot = 1'b1;
            cmd.clear_acc = (tap_ff == 2'd0);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.do_acc = 1'b1;
            if (tap_ff != 2'd2) begin
               tap_in = tap_ff + 2'd1;
               state_in = ST_ROT;
            end else begin
               tap_in = 2'd0;
               if (axis_ff != 2'd2) begin
                  axis_in = axis_ff + 2'd1;
                  state_in = ST_ROT;
               end else state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `DIU_ASSERT_NEXT(a_emit_valid, clock, reset, cmd.emit, rsp_valid)
   `DIU_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, state_ff == ST_IDLE)
   `DIU_ASSERT_IMP(a_emit_free, clock, reset, cmd.emit, !rsp_valid || rsp_ready)
endmodule
`default_nettype wire

// ===== sv/depth_image_unprojection_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// depth_image_unprojection_unit
// Pinhole unprojection of a depth raster stream into world points.
// ----------------------------------------------------------------------------
// Requests arrive on req_ with valid and ready: either a depth pixel in raster
// order or one pose word. Each kept pixel yields one world point on rsp_.
// The user must write configuration registers over csr_ only while the unit
// is idle; the unit does not enforce this. Requests are handled one at a
// time. A pose word or an unselected pixel passes through the depth and
// clamp states only, and a pixel dropped as too near also through the focal
// state. For a kept pixel the depth scale, two back-projections in two
// halves each and nine rotation products run in turn before its point is
// presented on rsp_.
// The result sits in an output register, so the next request is taken while
// the receiver stalls; only a second result then waits for it, and the input
// is held off meanwhile.
// Reset clears the counters, pose store and control; registers take defaults.
// ----------------------------------------------------------------------------
module depth_image_unprojection_unit #(
   parameter int ImageWidth  = diu_pkg::ImageWidthDefault,
   parameter int ImageHeight = diu_pkg::ImageHeightDefault,
   parameter int Skip        = diu_pkg::SkipDefault
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire diu_pkg::req_payload_type req_payload,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output diu_pkg::rsp_payload_type      rsp_payload,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [2:0]               csr_index,
   input  wire logic [23:0]              csr_data
);
   import diu_pkg::*;

   csr_type csr_ff;
   dp_cmd_type cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   // Register file: one write per handshake.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '{depth_unit: 24'd16777, min_depth: 24'd0, max_depth: 24'd327680,
                     inv_focal_x: 24'd43352, inv_focal_y: 24'd43352,
                     center_x: 16'd10240, center_y: 16'd7680, border_margin: 7'd0};
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_DEPTH_UNIT:    csr_ff.depth_unit    <= csr_data;
            CSR_MIN_DEPTH:     csr_ff.min_depth     <= csr_data;
            CSR_MAX_DEPTH:     csr_ff.max_depth     <= csr_data;
            CSR_INV_FOCAL_X:   csr_ff.inv_focal_x   <= csr_data;
            CSR_INV_FOCAL_Y:   csr_ff.inv_focal_y   <= csr_data;
            CSR_CENTER_X:      csr_ff.center_x      <= csr_data[15:0];
            CSR_CENTER_Y:      csr_ff.center_y      <= csr_data[15:0];
            CSR_BORDER_MARGIN: csr_ff.border_margin <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   diu_controller u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .status, .cmd
   );

   diu_datapath #(.ImageWidth(ImageWidth), .ImageHeight(ImageHeight), .Skip(Skip)) u_dp (
      .clock, .reset, .req_payload, .csr(csr_ff), .cmd, .status, .result(rsp_payload)
   );
endmodule
`default_nettype wire

// ===== tb/sv/depth_image_unprojection_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_image_unprojection_unit_tb
// Self-checking bench for the depth image unprojection unit.
// ----------------------------------------------------------------------------
// Depth pixels and pose words are sent as requests on req_. A predictor in
// the bench tracks pose, pixel position and point count, and queues the world
// point that each kept pixel should give. Every point seen on rsp_ is checked
// against the oldest queued one. The unit runs with its default raster size.
// ----------------------------------------------------------------------------
module depth_image_unprojection_unit_tb;
   import diu_pkg::*;

   localparam int ImgW      = ImageWidthDefault;
   localparam int ImgH      = ImageHeightDefault;
   localparam int SkipRate  = SkipDefault;
   localparam int CycleLimit = 2000000;
   localparam int DrainCycles = 40;
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_POSE  = 1'b1;
   localparam int POSE_POS_X = 9;
   localparam int POSE_COUNT = 12;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [23:0] csr_data = '0;

   depth_image_unprojection_unit #(
      .ImageWidth(ImgW), .ImageHeight(ImgH), .Skip(SkipRate)
   ) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   // Predictor state: a private copy of the registers, the pose and counters.
   csr_type         cfg;
   longint          pose [POSE_COUNT];
   int              col_pos, row_pos;
   logic [18:0]     cloud_count;
   rsp_payload_type expected_points [$];

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  hold_off_start = 1'b0;
   int  hold_off_left = 0;
   int  mismatches = 0;
   int  cycle_count = 0;

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------
   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic bit pixel_picked(int p, int size);
      int m;
      m = int'(cfg.border_margin);
      if (p < m || p >= size - m) return 1'b0;
      return ((p - m) % SkipRate) == 0;
   endfunction

   // Offset from the principal point times depth over focal length, rounded
   // half away from zero to Q16.16. The product is split in two halves so
   // every partial product fits in 64 bits.
   function automatic longint camera_offset(int pix, logic [15:0] center,
                                            longint unsigned depth,
                                            logic [23:0] inv_focal);
      longint          du;
      longint unsigned mag, prod, hi, lo, a, b, r;
      longint          s;
      du   = longint'(pix) * 32 - longint'(center);
      mag  = (du < 0) ? longint'(-du) : longint'(du);
      prod = depth * longint'(inv_focal);
      hi   = prod >> 24;
      lo   = prod & 64'hFF_FFFF;
      a    = mag * hi;
      b    = mag * lo + (64'd1 << 28);
      r    = (a >> 5) + ((((a & 64'd31) << 24) + b) >> 29);
      if (r > 64'h8000_0000) r = 64'h8000_0000;
      s = longint'(r);
      return sat32((du < 0) ? -s : s);
   endfunction

   task automatic predict_point(input req_payload_type r);
      longint unsigned depth;
      longint          cam [3];
      longint          w;
      bit              keep;
      rsp_payload_type p;
      if (r.cmd == CMD_POSE) begin
         if (r.pose_index < POSE_COUNT) pose[r.pose_index] = longint'(r.pose_value);
         return;
      end
      if (r.first_of_frame) begin
         col_pos = 0;
         row_pos = 0;
         cloud_count = '0;
      end
      if (pixel_picked(col_pos, ImgW) && pixel_picked(row_pos, ImgH)) begin
         depth = (longint'(r.depth_raw) * longint'(cfg.depth_unit) + 128) >> 8;
         keep = 1'b1;
         if (r.depth_raw == 0 || depth > cfg.max_depth) depth = cfg.max_depth;
         else if (depth < cfg.min_depth) keep = 1'b0;
         if (keep) begin
            cam[0] = camera_offset(col_pos, cfg.center_x, depth, cfg.inv_focal_x);
            cam[1] = camera_offset(row_pos, cfg.center_y, depth, cfg.inv_focal_y);
            cam[2] = longint'(depth);
            for (int ax = 0; ax < 3; ax++) begin
               w = pose[POSE_POS_X + ax];
               for (int k = 0; k < 3; k++)
                  w += (pose[ax * 3 + k] * cam[k] + 32768) >>> 16;
               w = sat32(w);
               if (ax == 0) p.point_x = w[31:0];
               else if (ax == 1) p.point_y = w[31:0];
               else p.point_z = w[31:0];
            end
            p.point_index = cloud_count;
            cloud_count++;
            expected_points = {expected_points, p};
         end
      end
      col_pos++;
      if (col_pos >= ImgW) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= ImgH) row_pos = 0;
      end
   endtask

   // ---------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_payload_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected point: %p", rsp_payload);
         end else begin
            want = expected_points.pop_front();
            if (want !== rsp_payload) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("point mismatch: expected %p, got %p", want, rsp_payload);
            end
         end
      end
   end

   // Receiver stalls. A long hold-off is counted down here, cycle by cycle,
   // once a test asks for one.
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_off_start) begin
            hold_off_start = 1'b0;
            hold_off_left = 300;
         end
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Shared helpers
   // ---------------------------------------------------------------------
   // Sends one request; the predictor sees it at the edge it is accepted.
   task automatic send_request(input req_payload_type r);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      predict_point(r);
   endtask

   // Lowers valid and waits for every point plus the unit's own latency,
   // since a dropped pixel may still be in flight.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [23:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_DEPTH_UNIT:    cfg.depth_unit    = val;
         CSR_MIN_DEPTH:     cfg.min_depth     = val;
         CSR_MAX_DEPTH:     cfg.max_depth     = val;
         CSR_INV_FOCAL_X:   cfg.inv_focal_x   = val;
         CSR_INV_FOCAL_Y:   cfg.inv_focal_y   = val;
         CSR_CENTER_X:      cfg.center_x      = val[15:0];
         CSR_CENTER_Y:      cfg.center_y      = val[15:0];
         CSR_BORDER_MARGIN: cfg.border_margin = val[6:0];
         default: ;
      endcase
   endtask

   function automatic req_payload_type pixel(input logic [15:0] raw, input logic first);
      req_payload_type r;
      r.cmd            = CMD_PIXEL;
      r.depth_raw      = raw;
      r.first_of_frame = first;
      r.pose_index     = 4'($urandom);
      r.pose_value     = $urandom;
      return r;
   endfunction

   function automatic req_payload_type pose_word(input logic [3:0] idx,
                                                 input logic [31:0] val);
      req_payload_type r;
      r.cmd            = CMD_POSE;
      r.depth_raw      = 16'($urandom);
      r.first_of_frame = 1'($urandom);
      r.pose_index     = idx;
      r.pose_value     = val;
      return r;
   endfunction

   // Pose words mostly near unity scale, now and then anything at all.
   function automatic logic [31:0] random_pose_value();
      if ($urandom_range(9) == 0) return $urandom;
      return 32'($signed($urandom_range(262143)) - 131072);
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_identity_pose();
      send_request(pose_word(4'd0, 32'h0001_0000));
      send_request(pose_word(4'd4, 32'h0001_0000));
      send_request(pose_word(4'd8, 32'h0001_0000));
      send_request(pixel(16'd1000, 1'b1));
      send_request(pixel(16'd0, 1'b0));
      send_request(pixel(16'hFFFF, 1'b0));
      wait_idle();
   endtask

   // Extreme pose words, and indexes past the store that must be ignored.
   task automatic test_pose_words();
      send_request(pose_word(4'd1, 32'h7FFF_FFFF));
      send_request(pose_word(4'd9, 32'h8000_0000));
      send_request(pose_word(4'd11, 32'h7FFF_FFFF));
      for (int i = 12; i < 16; i++) send_request(pose_word(4'(i), 32'h1234_5678));
      send_request(pixel(16'd500, 1'b1));
      send_request(pixel(16'd500, 1'b0));
      send_request(pixel(16'd500, 1'b0));
      wait_idle();
   endtask

   // A reading at the minimum kept, far ones clamped, and the scale at both ends.
   task automatic test_depth_limits();
      write_csr(CSR_MIN_DEPTH, 24'd65536);
      write_csr(CSR_MAX_DEPTH, 24'hFF_FFFF);
      write_csr(CSR_DEPTH_UNIT, 24'hFF_FFFF);
      send_request(pixel(16'd1, 1'b1));
      send_request(pixel(16'd1, 1'b0));
      send_request(pixel(16'hFFFF, 1'b0));
      wait_idle();
      write_csr(CSR_DEPTH_UNIT, 24'd0);
      write_csr(CSR_MIN_DEPTH, 24'd0);
      send_request(pixel(16'hFFFF, 1'b1));
      wait_idle();
   endtask

   // A wide margin leaves the top rows empty; extreme centres and focals.
   task automatic test_margin_and_optics();
      write_csr(CSR_BORDER_MARGIN, 24'd64);
      for (int i = 0; i < 6; i++) send_request(pixel(16'd800, i == 0));
      wait_idle();
      write_csr(CSR_BORDER_MARGIN, 24'd3);
      write_csr(CSR_CENTER_X, 24'h00_FFFF);
      write_csr(CSR_CENTER_Y, 24'd0);
      write_csr(CSR_INV_FOCAL_X, 24'hFF_FFFF);
      write_csr(CSR_INV_FOCAL_Y, 24'd0);
      write_csr(CSR_DEPTH_UNIT, 24'd16777);
      write_csr(CSR_MAX_DEPTH, 24'd327680);
      for (int i = 0; i < 64; i++) send_request(pixel(16'($urandom), i == 0));
      wait_idle();
   endtask

   task automatic randomise_config(input bit extremes);
      if (extremes) begin
         write_csr(CSR_DEPTH_UNIT, $urandom_range(1) ? 24'hFF_FFFF : 24'd1);
         write_csr(CSR_MIN_DEPTH, 24'd0);
         write_csr(CSR_MAX_DEPTH, 24'hFF_FFFF);
         write_csr(CSR_INV_FOCAL_X, 24'hFF_FFFF);
         write_csr(CSR_INV_FOCAL_Y, 24'hFF_FFFF);
         write_csr(CSR_CENTER_X, 24'd0);
         write_csr(CSR_CENTER_Y, 24'h00_FFFF);
         write_csr(CSR_BORDER_MARGIN, 24'd0);
      end else begin
         write_csr(CSR_DEPTH_UNIT, 24'($urandom_range(100000)));
         write_csr(CSR_MIN_DEPTH, 24'($urandom_range(30000)));
         write_csr(CSR_MAX_DEPTH, 24'($urandom_range(24'hFF_FFFF)));
         write_csr(CSR_INV_FOCAL_X, 24'($urandom));
         write_csr(CSR_INV_FOCAL_Y, 24'($urandom));
         write_csr(CSR_CENTER_X, 24'($urandom_range(16'hFFFF)));
         write_csr(CSR_CENTER_Y, 24'($urandom_range(16'hFFFF)));
         write_csr(CSR_BORDER_MARGIN, 24'($urandom_range(9)));
      end
   endtask

   // Frames of random depth with a pose refresh now and then, and a few
   // first-of-frame marks out of place.
   task automatic test_random_stream(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(19) == 0)
            send_request(pose_word(4'($urandom), random_pose_value()));
         else
            send_request(pixel(16'($urandom), $urandom_range(99) == 0));
      end
      wait_idle();
   endtask

   // The receiver holds off while requests keep coming, so the unit fills up.
   task automatic test_backpressure();
      hold_off_start = 1'b1;
      for (int i = 0; i < 40; i++) send_request(pixel(16'($urandom), i == 0));
      wait_idle();
   endtask

   initial begin
      cfg = '{depth_unit: 24'd16777, min_depth: 24'd0, max_depth: 24'd327680,
              inv_focal_x: 24'd43352, inv_focal_y: 24'd43352,
              center_x: 16'd10240, center_y: 16'd7680, border_margin: 7'd0};
      foreach (pose[i]) pose[i] = 0;
      col_pos = 0;
      row_pos = 0;
      cloud_count = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_identity_pose();
      test_pose_words();
      test_depth_limits();
      test_margin_and_optics();

      send_idle_pct = 25;
      recv_idle_pct = 53;
      randomise_config(1'b0);
      test_random_stream(330);
      test_backpressure();
      send_idle_pct = 53;
      recv_idle_pct = 25;
      randomise_config(1'b1);
      test_random_stream(330);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      randomise_config(1'b0);
      test_random_stream(330);

      if (mismatches == 0 && expected_points.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
